[rtl/core/srfx_pkg.sv]
`timescale 1ns / 1ps

package srfx_pkg;

    localparam logic [7:0]  SYNC_A_BYTE  = 8'h55;
    localparam logic [7:0]  SYNC_B_BYTE  = 8'hAA;
    localparam logic [7:0]  TYPE_BYTE    = 8'h02;
    localparam logic [7:0]  PAD_BYTE     = 8'h00;
    localparam logic [15:0] OVERHEAD     = 16'd7;
    localparam logic [15:0] LEN_RESET    = 16'd500;
    localparam logic [15:0] LEN_HI_MASK  = 16'hFF00;
    localparam logic [15:0] LEN_LO_MASK  = 16'h00FF;

    // one accepted payload byte, classified for the back end
    typedef struct packed {
        logic [7:0] data;
        logic       first;
        logic       last;
        logic [7:0] len_hi;
        logic [7:0] len_lo;
        logic [7:0] chk;
    } srfx_entry_t;

endpackage

[rtl/core/srfx_front.sv]
`timescale 1ns / 1ps

module srfx_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    input  logic [15:0]          cfg_data,
    input  logic                 push,
    input  logic [7:0]           payload_byte,
    output srfx_pkg::srfx_entry_t entry
);
    import srfx_pkg::*;

    logic [15:0] payload_length_reg;
    logic [15:0] bytes_sent_reg;
    logic [15:0] bytes_sent_next;
    logic [7:0]  running_xor_reg;
    logic [7:0]  running_xor_next;
    logic [15:0] len_eff;
    logic [15:0] total;
    logic [15:0] sent_inc;
    logic [7:0]  hi;
    logic [7:0]  lo;
    logic        first;
    logic        last;
    logic [7:0]  xor_base;
    logic [7:0]  xor_new;

    always_comb
    begin
        len_eff  = (payload_length_reg == 16'd0) ? 16'd1 : payload_length_reg;
        total    = payload_length_reg + OVERHEAD;
        hi       = 8'((total & LEN_HI_MASK) >> 8);
        lo       = 8'(total & LEN_LO_MASK);
        first    = (bytes_sent_reg == 16'd0);
        sent_inc = bytes_sent_reg + 16'd1;
        last     = (sent_inc >= len_eff);
        // header bytes seed the checksum at the start of a frame
        xor_base = first ? (SYNC_A_BYTE ^ SYNC_B_BYTE ^ hi ^ lo ^ TYPE_BYTE)
                         : running_xor_reg;
        xor_new  = xor_base ^ payload_byte;

        entry.data   = payload_byte;
        entry.first  = first;
        entry.last   = last;
        entry.len_hi = hi;
        entry.len_lo = lo;
        entry.chk    = xor_new ^ PAD_BYTE;

        bytes_sent_next  = bytes_sent_reg;
        running_xor_next = running_xor_reg;
        if (push)
        begin
            bytes_sent_next  = last ? 16'd0 : sent_inc;
            running_xor_next = last ? 8'd0 : xor_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            payload_length_reg <= LEN_RESET;
            bytes_sent_reg     <= 16'd0;
            running_xor_reg    <= 8'd0;
        end
        else
        begin
            if (cfg_valid)
            begin
                payload_length_reg <= cfg_data;
            end
            bytes_sent_reg  <= bytes_sent_next;
            running_xor_reg <= running_xor_next;
        end
    end

    // a frame-ending item leaves the counter at zero
    assert property (@(posedge clk) disable iff (!rst_n)
        push && entry.last |=> bytes_sent_reg == 16'd0)
        else $error("frame counter not cleared after last item");

endmodule

[rtl/core/srfx_queue.sv]
`timescale 1ns / 1ps

module srfx_queue
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  srfx_pkg::srfx_entry_t push_entry,
    input  logic                 pop,
    output srfx_pkg::srfx_entry_t head,
    output logic                 not_empty,
    output logic                 full
);
    import srfx_pkg::*;

    srfx_entry_t slot_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;

    always_comb
    begin
        head       = slot_reg[rd_ptr_reg];
        not_empty  = (count_reg != 2'd0);
        full       = (count_reg == 2'd2);
        count_next = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("push into full queue");
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> not_empty)
        else $error("pop from empty queue");
    assert property (@(posedge clk) disable iff (!rst_n) count_reg != 2'd3)
        else $error("queue count out of range");

endmodule

[rtl/core/srfx_back.sv]
`timescale 1ns / 1ps

module srfx_back
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  srfx_pkg::srfx_entry_t head,
    input  logic                 not_empty,
    output logic                 pop,
    output logic                 frame_valid,
    input  logic                 frame_stall,
    output logic [7:0]           frame_byte,
    output logic                 frame_end
);
    import srfx_pkg::*;

    localparam logic [2:0] PH_SYNC_A = 3'd0;
    localparam logic [2:0] PH_SYNC_B = 3'd1;
    localparam logic [2:0] PH_LEN_HI = 3'd2;
    localparam logic [2:0] PH_LEN_LO = 3'd3;
    localparam logic [2:0] PH_TYPE   = 3'd4;
    localparam logic [2:0] PH_DATA   = 3'd5;
    localparam logic [2:0] PH_PAD    = 3'd6;
    localparam logic [2:0] PH_CHK    = 3'd7;

    logic [2:0] phase_reg;
    logic [2:0] phase_next;
    logic       started_reg;
    logic       started_next;
    logic       frame_valid_reg;
    logic       frame_valid_next;
    logic [7:0] frame_byte_reg;
    logic       frame_end_reg;
    logic [2:0] cur_phase;
    logic       out_free;
    logic       emit;
    logic       entry_done;
    logic [7:0] byte_sel;

    always_comb
    begin
        cur_phase  = started_reg ? phase_reg : (head.first ? PH_SYNC_A : PH_DATA);
        out_free   = !frame_valid_reg || !frame_stall;
        emit       = not_empty && out_free;
        entry_done = (cur_phase == PH_CHK) || (cur_phase == PH_DATA && !head.last);
        pop        = emit && entry_done;

        case (cur_phase)
            PH_SYNC_A: byte_sel = SYNC_A_BYTE;
            PH_SYNC_B: byte_sel = SYNC_B_BYTE;
            PH_LEN_HI: byte_sel = head.len_hi;
            PH_LEN_LO: byte_sel = head.len_lo;
            PH_TYPE:   byte_sel = TYPE_BYTE;
            PH_DATA:   byte_sel = head.data;
            PH_PAD:    byte_sel = PAD_BYTE;
            PH_CHK:    byte_sel = head.chk;
            default:   byte_sel = PAD_BYTE;
        endcase

        phase_next   = phase_reg;
        started_next = started_reg;
        if (emit)
        begin
            started_next = !entry_done;
            phase_next   = cur_phase + 3'd1;
        end

        frame_valid_next = emit || (frame_valid_reg && frame_stall);
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            frame_byte_reg <= byte_sel;
            frame_end_reg  <= (cur_phase == PH_CHK);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_SYNC_A;
            started_reg     <= 1'b0;
            frame_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg       <= phase_next;
            started_reg     <= started_next;
            frame_valid_reg <= frame_valid_next;
        end
    end

    assign frame_valid = frame_valid_reg;
    assign frame_byte  = frame_byte_reg;
    assign frame_end   = frame_end_reg;

    // the checksum byte only goes out for an item that closes a frame
    assert property (@(posedge clk) disable iff (!rst_n)
        emit && cur_phase == PH_CHK |-> head.last)
        else $error("checksum emitted for item that does not end a frame");

endmodule

[rtl/core/sample_record_framer_xor.sv]
`timescale 1ns / 1ps
// channel   signals                               dir
// payload   payload_valid, payload_stall,          in
//           payload_byte
// frame     frame_valid, frame_stall,              out
//           frame_byte, frame_end
// cfg       cfg_valid, cfg_ready, cfg_data         in (payload_length)
//
// a payload item is taken every cycle while the two-entry item queue has room
// the back end sends one byte per cycle unless frame_stall holds it: 1 byte per item,
// +5 on the first item of a frame, +2 on the last, so throughput is set by the output byte sequencer
// reset clears the frame counter, checksum, queue pointers and output valid flag and
// loads payload_length with 500
// frame_stall holds the output register; payload_stall rises when the queue is full

module sample_record_framer_xor
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        payload_valid,
    output logic        payload_stall,
    input  logic [7:0]  payload_byte,
    output logic        frame_valid,
    input  logic        frame_stall,
    output logic [7:0]  frame_byte,
    output logic        frame_end,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);
    import srfx_pkg::*;

    srfx_entry_t entry;
    srfx_entry_t head;
    logic        push;
    logic        pop;
    logic        not_empty;
    logic        full;

    assign payload_stall = full;
    assign push          = payload_valid && !full;
    assign cfg_ready     = 1'b1;

    srfx_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_data     (cfg_data),
        .push         (push),
        .payload_byte (payload_byte),
        .entry        (entry)
    );

    srfx_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (entry),
        .pop        (pop),
        .head       (head),
        .not_empty  (not_empty),
        .full       (full)
    );

    srfx_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .not_empty   (not_empty),
        .pop         (pop),
        .frame_valid (frame_valid),
        .frame_stall (frame_stall),
        .frame_byte  (frame_byte),
        .frame_end   (frame_end)
    );

endmodule
